@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the statistic core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/chisq_pkg.sv @@
// ----------------------------------------------------------------------------
// chisq_pkg
// Widths, codes and types shared by the chi-square statistic core.
// ----------------------------------------------------------------------------
package chisq_pkg;

  localparam int MAX_LIBS   = 32;
  localparam int LIB_IDX_W  = $clog2(MAX_LIBS);
  localparam int ENTRY_W    = LIB_IDX_W + 1;
  localparam int COUNT_BITS = 20;
  localparam int FRAC_BITS  = 16;
  localparam int TOT_W      = 26;
  localparam int COL_W      = COUNT_BITS + 1;
  localparam int PROD_W     = COUNT_BITS + TOT_W;   // c * total, also |d|
  localparam int MUL_W      = PROD_W + 1;           // widest multiply operand
  localparam int PROD2_W    = 2 * MUL_W;            // multiply result
  localparam int DSQ_W      = 2 * PROD_W;           // d * d
  localparam int DEN_W      = COL_W + 2 * TOT_W;    // col * tot1 * tot2
  localparam int QUOT_W     = TOT_W + FRAC_BITS + 2;
  localparam int REM_W      = DEN_W + 1;
  localparam int WORK_W     = REM_W + QUOT_W;
  localparam int DIV_PAD_W  = WORK_W - DSQ_W - FRAC_BITS;
  localparam int CHI_W      = 42;
  localparam int SUM_W      = QUOT_W + 1;
  localparam int MUL_STEPS  = MUL_W;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int STEP_W     = $clog2(MUL_STEPS);

  localparam logic [CHI_W-1:0] CHI_MAX = '1;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_ROW = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // Shared unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } mdu_req_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] second;
    logic [COUNT_BITS-1:0] first;
  } count_pair_t;

endpackage

@@ hw/rtl/chisq_store.sv @@
// ----------------------------------------------------------------------------
// chisq_store
// Count pair memory, one entry per library, registered read.
// ----------------------------------------------------------------------------
module chisq_store import chisq_pkg::*; (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [LIB_IDX_W-1:0] wr_addr,
  input  count_pair_t          wr_data,
  input  logic [LIB_IDX_W-1:0] rd_addr,
  output count_pair_t          rd_data
);

  count_pair_t mem [MAX_LIBS];

  // Write one pair per accepted beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle, data registered for the cycle after the address
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/chisq_mdu.sv @@
// ----------------------------------------------------------------------------
// chisq_mdu
// Shared iterative multiply / divide unit built round one adder.
// Multiply: shift-add, one multiplier bit a cycle. Divide: restoring,
// one quotient bit a cycle, dividend scaled by 2^FRAC_BITS.
// ----------------------------------------------------------------------------
module chisq_mdu import chisq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mdu_req_t           req,
  input  logic [DEN_W-1:0]   a_in,   // multiplicand or divisor
  input  logic [DSQ_W-1:0]   b_in,   // multiplier or dividend
  output logic               done,
  output logic [PROD2_W-1:0] res     // product, or quotient in the low bits
);

  logic [WORK_W-1:0] work;
  logic [WORK_W-1:0] work_next;
  logic [DEN_W-1:0]  opnd;
  logic              op;
  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic              last_step;

  logic [REM_W-1:0]  add_x;
  logic [REM_W-1:0]  add_y;
  logic              add_ci;
  logic [REM_W:0]    add_s;

  // Operand select for the single adder
  always_comb begin
    if (op == OP_DIV) begin
      add_x  = work[WORK_W-2:QUOT_W-1];
      add_y  = ~REM_W'(opnd);
      add_ci = 1'b1;
    end else begin
      add_x  = REM_W'(work[PROD2_W-1:MUL_W]);
      add_y  = work[0] ? REM_W'(opnd[MUL_W-1:0]) : '0;
      add_ci = 1'b0;
    end
    add_s = {1'b0, add_x} + {1'b0, add_y} + (REM_W + 1)'(add_ci);
  end

  // Next work word: shift in a quotient bit, or shift the product right
  always_comb begin
    if (op == OP_DIV) begin
      work_next = {(add_s[REM_W] ? add_s[REM_W-1:0] : add_x),
                   work[QUOT_W-2:0], add_s[REM_W]};
    end else begin
      work_next = WORK_W'({add_s[MUL_W:0], work[MUL_W-1:1]});
    end
  end

  assign last_step = (op == OP_DIV) ? (cnt == STEP_W'(DIV_STEPS - 1))
                                    : (cnt == STEP_W'(MUL_STEPS - 1));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      opnd <= a_in;
      if (req.op == OP_DIV) begin
        work <= {{DIV_PAD_W{1'b0}}, b_in, {FRAC_BITS{1'b0}}};
      end else begin
        work <= WORK_W'(b_in[MUL_W-1:0]);
      end
    end else if (busy) begin
      work <= work_next;
    end
  end

  assign res = work[PROD2_W-1:0];

endmodule

@@ hw/rtl/chi_square_two_row_statistic_core.sv @@
// ----------------------------------------------------------------------------
// chi_square_two_row_statistic_core
// Pearson chi-square statistic of a 2-by-N table of library counts.
//
//   channel   dir  beat contents (tdata low bit up)          tlast
//   s_axis    in   count_first[19:0], count_second[39:20]      last_lib
//   m_axis    out  chi_stat[41:0], status[43:42], zeros      -
//
// Pairs load one per cycle while the table builds. After the last pair a
// sequencer runs each stored library through one shared multiply/divide
// unit: five 47-step multiplies and one 44-step divide; a library whose
// counts are both zero skips the unit. s_axis_tready is low from the last
// pair until the result beat is taken. rst is synchronous; the pair memory
// is not cleared.
// ----------------------------------------------------------------------------
module chi_square_two_row_statistic_core import chisq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // count_first, count_second
  input  logic        s_axis_tlast,   // last_lib
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // chi_stat, status, zero pad
);

  `include "assert_macros.svh"

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_MC   = 4'd3;
  localparam logic [3:0] ST_ME   = 4'd4;
  localparam logic [3:0] ST_MA   = 4'd5;
  localparam logic [3:0] ST_MB   = 4'd6;
  localparam logic [3:0] ST_MD   = 4'd7;
  localparam logic [3:0] ST_DV   = 4'd8;
  localparam logic [3:0] ST_NXT  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [TOT_W-1:0]     total_first;
  logic [TOT_W-1:0]     total_second;
  logic [ENTRY_W-1:0]   entry_count;
  logic                 overflow_flag;
  logic [LIB_IDX_W-1:0] idx;
  logic [CHI_W-1:0]     chi_sum;
  logic [1:0]           status;
  logic [DEN_W-1:0]     den;
  logic [PROD_W-1:0]    prod_a;

  count_pair_t          in_pair;
  count_pair_t          rd_pair;
  logic                 in_beat;
  logic                 out_beat;
  logic                 room;
  logic [TOT_W-1:0]     tot1_new;
  logic [TOT_W-1:0]     tot2_new;
  logic [COL_W-1:0]     col;
  logic [PROD_W-1:0]    diff;
  logic [SUM_W-1:0]     sum_ext;

  mdu_req_t             mreq;
  logic [DEN_W-1:0]     m_a;
  logic [DSQ_W-1:0]     m_b;
  logic                 m_done;
  logic [PROD2_W-1:0]   m_res;

  assign in_pair.first  = s_axis_tdata[COUNT_BITS-1:0];
  assign in_pair.second = s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign room          = (entry_count < ENTRY_W'(MAX_LIBS));

  assign tot1_new = room ? total_first  + TOT_W'(in_pair.first)  : total_first;
  assign tot2_new = room ? total_second + TOT_W'(in_pair.second) : total_second;

  assign col     = COL_W'(rd_pair.first) + COL_W'(rd_pair.second);
  assign diff    = (prod_a >= m_res[PROD_W-1:0]) ? prod_a - m_res[PROD_W-1:0]
                                                 : m_res[PROD_W-1:0] - prod_a;
  assign sum_ext = SUM_W'(chi_sum) + SUM_W'(m_res[QUOT_W-1:0]);

  chisq_store u_store (
    .clk     (clk),
    .wr_en   (in_beat && room),
    .wr_addr (entry_count[LIB_IDX_W-1:0]),
    .wr_data (in_pair),
    .rd_addr (idx),
    .rd_data (rd_pair)
  );

  chisq_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a_in (m_a),
    .b_in (m_b),
    .done (m_done),
    .res  (m_res)
  );

  // Sequence one library: col*T1, *T2, c1*T2, c2*T1, d*d, then divide
  always_comb begin
    state_next = state;
    mreq.start = 1'b0;
    mreq.op    = OP_MUL;
    m_a        = DEN_W'(total_first);
    m_b        = DSQ_W'(col);
    unique case (state)
      ST_IDLE: begin
        if (in_beat && s_axis_tlast) begin
          if (overflow_flag || !room || tot1_new == '0 || tot2_new == '0) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_RD:   state_next = ST_CHK;
      ST_CHK: begin
        if (col == '0) begin
          state_next = ST_NXT;
        end else begin
          mreq.start = 1'b1;
          state_next = ST_MC;
        end
      end
      ST_MC: begin
        m_a = DEN_W'(m_res[MUL_W-1:0]);
        m_b = DSQ_W'(total_second);
        if (m_done) begin
          mreq.start = 1'b1;
          state_next = ST_ME;
        end
      end
      ST_ME: begin
        m_a = DEN_W'(total_second);
        m_b = DSQ_W'(rd_pair.first);
        if (m_done) begin
          mreq.start = 1'b1;
          state_next = ST_MA;
        end
      end
      ST_MA: begin
        m_a = DEN_W'(total_first);
        m_b = DSQ_W'(rd_pair.second);
        if (m_done) begin
          mreq.start = 1'b1;
          state_next = ST_MB;
        end
      end
      ST_MB: begin
        m_a = DEN_W'(diff);
        m_b = DSQ_W'(diff);
        if (m_done) begin
          mreq.start = 1'b1;
          state_next = ST_MD;
        end
      end
      ST_MD: begin
        mreq.op = OP_DIV;
        m_a     = den;
        m_b     = m_res[DSQ_W-1:0];
        if (m_done) begin
          mreq.start = 1'b1;
          state_next = ST_DV;
        end
      end
      ST_DV: begin
        if (m_done) begin
          state_next = ST_NXT;
        end
      end
      ST_NXT: begin
        if (ENTRY_W'(idx) + ENTRY_W'(1) == entry_count) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_beat) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: table totals, counters, status
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      total_first   <= '0;
      total_second  <= '0;
      entry_count   <= '0;
      overflow_flag <= 1'b0;
      idx           <= '0;
      status        <= STAT_OK;
    end else begin
      state <= state_next;
      if (in_beat) begin
        total_first  <= tot1_new;
        total_second <= tot2_new;
        if (room) begin
          entry_count <= entry_count + ENTRY_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
        idx <= '0;
        priority if (overflow_flag || !room) begin
          status <= STAT_OVERFLOW;
        end else if (tot1_new == '0 || tot2_new == '0) begin
          status <= STAT_ZERO_ROW;
        end else begin
          status <= STAT_OK;
        end
      end
      if (state == ST_NXT) begin
        idx <= idx + LIB_IDX_W'(1);
      end
      // Drop the finished table once the result beat is taken
      if (out_beat) begin
        total_first   <= '0;
        total_second  <= '0;
        entry_count   <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // Payload: held products and running sum
  always_ff @(posedge clk) begin
    if (in_beat) begin
      chi_sum <= '0;
    end
    if (state == ST_ME && m_done) begin
      den <= m_res[DEN_W-1:0];
    end
    if (state == ST_MA && m_done) begin
      prod_a <= m_res[PROD_W-1:0];
    end
    if (state == ST_DV && m_done) begin
      chi_sum <= (sum_ext[SUM_W-1:CHI_W] != '0) ? CHI_MAX : sum_ext[CHI_W-1:0];
    end
  end

  assign m_axis_tdata = {4'b0, status, (status == STAT_OK) ? chi_sum : CHI_W'(0)};

  // Checks
  `ASSERT_IMP(a_one_side, s_axis_tready, !m_axis_tvalid)
  `ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tdata[43:42] != STAT_OK,
              m_axis_tdata[41:0] == '0)
  `ASSERT_NEXT(a_clear, m_axis_tvalid && m_axis_tready,
               entry_count == '0 && total_first == '0 && !overflow_flag)
  `ASSERT_IMP(a_done_wait, m_done,
              state == ST_MC || state == ST_ME || state == ST_MA ||
              state == ST_MB || state == ST_MD || state == ST_DV)

endmodule
